// File: design/hufftw_pkg.sv
// Package for the tree-walk decoder: field widths, codes, payload and control types.
package hufftw_pkg;

	localparam int IDX_W           = 9;
	localparam int SYM_W           = 8;
	localparam int BYTE_BITS       = 8;
	localparam int BIT_IDX_W       = $clog2(BYTE_BITS);
	localparam int BIT_CNT_W       = $clog2(BYTE_BITS + 1);
	localparam int TOTAL_W         = 32;
	localparam int CFG_IDX_W       = 2;
	localparam int CFG_DATA_W      = 32;
	localparam int NODE_COUNT_DEF  = 512;
	localparam int SYMBOL_BITS_DEF = 8;

	localparam logic REQ_LOAD = 1'b0;
	localparam logic REQ_DATA = 1'b1;

	localparam logic ORDER_MSB_FIRST = 1'b0;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ROOT  = 2'd0,
		CFG_ORDER = 2'd1,
		CFG_TOTAL = 2'd2
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_BIT,
		ST_STEP,
		ST_CHILD,
		ST_FLUSH
	} state_t;

	typedef struct packed {
		logic             req_type;
		logic [IDX_W-1:0] node_index;
		logic             node_is_leaf;
		logic [IDX_W-1:0] node_left;
		logic [IDX_W-1:0] node_right;
		logic [SYM_W-1:0] node_symbol;
		logic [7:0]       data_byte;
	} in_item_t;

	typedef struct packed {
		logic [SYM_W-1:0] symbol;
		logic             last_of_run;
		logic             final_symbol;
	} out_item_t;

	// controller -> datapath
	typedef struct packed {
		logic load;      // write node, restart walk, clear count
		logic take;      // latch data byte, clear bit count
		logic rd_here;   // read node the walk stands on
		logic rd_child;  // read child chosen by current bit
		logic emit;      // new symbol from read data
		logic go_root;   // walk back to root after a leaf
		logic descend;   // walk moves to the child just read
		logic adv;       // next bit of the byte
		logic flush;     // push held symbol as last of run
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic bits_left;
		logic last_bit;
		logic total_hit;
		logic at_root;
		logic rd_leaf;
		logic pend_valid;
		logic emit_ok;
		logic out_free;
	} status_t;

endpackage

// File: design/hufftw_ctrl.sv
// Sequencer for the tree walk: one node read per step, emission and run flush.
module hufftw_ctrl
	import hufftw_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	input  logic    req_type,
	input  status_t st,
	output cmd_t    cmd,
	output logic    busy
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid && req_type == REQ_DATA) begin
					state_d = ST_BIT;
				end
			end
			ST_BIT: begin
				if (!st.bits_left || st.total_hit) begin
					state_d = ST_FLUSH;
				end else begin
					state_d = ST_STEP;
				end
			end
			ST_STEP: begin
				if (st.at_root && st.rd_leaf) begin
					if (st.emit_ok) begin
						state_d = ST_BIT;
					end
				end else begin
					state_d = ST_CHILD;
				end
			end
			ST_CHILD: begin
				if (st.rd_leaf) begin
					if (st.emit_ok) begin
						state_d = ST_BIT;
					end
				end else if (st.last_bit) begin
					state_d = ST_BIT;
				end else begin
					// child data already in the read register
					state_d = ST_STEP;
				end
			end
			ST_FLUSH: begin
				if (!st.pend_valid || st.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd  = '0;
		busy = 1'b1;
		case (state_q)
			ST_IDLE: begin
				busy     = 1'b0;
				cmd.load = in_valid && req_type == REQ_LOAD;
				cmd.take = in_valid && req_type == REQ_DATA;
			end
			ST_BIT: begin
				cmd.rd_here = st.bits_left && !st.total_hit;
			end
			ST_STEP: begin
				if (st.at_root && st.rd_leaf) begin
					cmd.emit = st.emit_ok;
					cmd.adv  = st.emit_ok;
				end else begin
					cmd.rd_child = 1'b1;
				end
			end
			ST_CHILD: begin
				if (st.rd_leaf) begin
					cmd.emit    = st.emit_ok;
					cmd.go_root = st.emit_ok;
					cmd.adv     = st.emit_ok;
				end else begin
					cmd.descend = 1'b1;
					cmd.adv     = 1'b1;
				end
			end
			ST_FLUSH: begin
				cmd.flush = st.pend_valid && st.out_free;
			end
			default: begin
				cmd  = '0;
				busy = 1'b1;
			end
		endcase
	end

endmodule

// File: design/hufftw_dp.sv
// Datapath: node table, walk position, symbol count, held symbol and output register.
module hufftw_dp
	import hufftw_pkg::*;
#(
	parameter int NODE_COUNT  = NODE_COUNT_DEF,
	parameter int SYMBOL_BITS = SYMBOL_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  in_item_t              in_data,
	input  logic                  out_stall,
	output logic                  out_valid,
	output out_item_t             out_data,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  cmd_t                  cmd,
	output status_t               st
);

	localparam int AW = $clog2(NODE_COUNT);

	typedef struct packed {
		logic                   leaf;
		logic [IDX_W-1:0]       left;
		logic [IDX_W-1:0]       right;
		logic [SYMBOL_BITS-1:0] sym;
	} node_t;

	node_t node_mem [NODE_COUNT];

	logic [IDX_W-1:0]     root_q;
	logic                 order_q;
	logic [TOTAL_W-1:0]   total_q;
	logic [IDX_W-1:0]     cur_q;
	logic                 at_root_q;
	logic [TOTAL_W-1:0]   given_q;
	logic [7:0]           byte_q;
	logic [BIT_CNT_W-1:0] bit_cnt_q;
	logic [IDX_W-1:0]     next_q;
	node_t                mem_rd_q;
	logic                 rd_oor_q;
	logic [SYM_W-1:0]     pend_sym_q;
	logic                 pend_final_q;
	logic                 pend_vld_q;
	out_item_t            out_q;
	logic                 out_vld_q;

	node_t                rd;
	logic [IDX_W-1:0]     here_idx;
	logic [IDX_W-1:0]     next_idx;
	logic [IDX_W-1:0]     rd_idx;
	logic [BIT_IDX_W-1:0] bit_sel;
	logic                 cur_bit;
	logic [TOTAL_W-1:0]   given_inc;
	logic                 out_free;
	logic                 wr_in_range;
	logic                 rd_in_range;
	node_t                wr_node;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			root_q  <= '0;
			order_q <= ORDER_MSB_FIRST;
			total_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_ROOT:  root_q  <= cfg_data[IDX_W-1:0];
				CFG_ORDER: order_q <= cfg_data[0];
				CFG_TOTAL: total_q <= cfg_data[TOTAL_W-1:0];
				default:   ;
			endcase
		end
	end

	// an index past the table reads as an all-zero node
	assign rd  = rd_oor_q ? '0 : mem_rd_q;

	assign bit_sel  = order_q ? bit_cnt_q[BIT_IDX_W-1:0]
	                          : BIT_IDX_W'(BYTE_BITS - 1) - bit_cnt_q[BIT_IDX_W-1:0];
	assign cur_bit  = byte_q[bit_sel];
	assign here_idx = at_root_q ? root_q : cur_q;
	assign next_idx = cur_bit ? rd.right : rd.left;
	assign rd_idx   = cmd.rd_child ? next_idx : here_idx;

	assign wr_in_range = 32'(in_data.node_index) < NODE_COUNT;
	assign rd_in_range = 32'(rd_idx) < NODE_COUNT;

	assign wr_node.leaf  = in_data.node_is_leaf;
	assign wr_node.left  = in_data.node_left;
	assign wr_node.right = in_data.node_right;
	assign wr_node.sym   = SYMBOL_BITS'(in_data.node_symbol);

	always_ff @(posedge clk) begin
		if (cmd.load && wr_in_range) begin
			node_mem[AW'(in_data.node_index)] <= wr_node;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd_here || cmd.rd_child) begin
			mem_rd_q <= node_mem[AW'(rd_idx)];
			rd_oor_q <= !rd_in_range;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd_child) begin
			next_q <= next_idx;
		end
		if (cmd.take) begin
			byte_q <= in_data.data_byte;
		end
	end

	// walk position, bit count, symbol count
	assign given_inc = given_q + TOTAL_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q     <= '0;
			at_root_q <= 1'b1;
			given_q   <= '0;
			bit_cnt_q <= '0;
		end else begin
			if (cmd.load) begin
				cur_q     <= '0;
				at_root_q <= 1'b1;
				given_q   <= '0;
			end else begin
				if (cmd.go_root) begin
					cur_q     <= root_q;
					at_root_q <= 1'b1;
				end else if (cmd.descend) begin
					cur_q     <= next_q;
					at_root_q <= 1'b0;
				end
				if (cmd.emit) begin
					given_q <= given_inc;
				end
			end
			if (cmd.take) begin
				bit_cnt_q <= '0;
			end else if (cmd.adv) begin
				bit_cnt_q <= bit_cnt_q + BIT_CNT_W'(1);
			end
		end
	end

	// one symbol is held back until it is known whether another follows in this byte
	assign out_free = !out_vld_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_vld_q <= 1'b0;
			out_vld_q  <= 1'b0;
		end else begin
			if (cmd.emit) begin
				pend_vld_q <= 1'b1;
			end else if (cmd.flush) begin
				pend_vld_q <= 1'b0;
			end
			if ((cmd.emit && pend_vld_q) || cmd.flush) begin
				out_vld_q <= 1'b1;
			end else if (!out_stall) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			pend_sym_q   <= SYM_W'(rd.sym);
			pend_final_q <= given_inc == total_q;
		end
		if ((cmd.emit && pend_vld_q) || cmd.flush) begin
			out_q.symbol       <= pend_sym_q;
			out_q.last_of_run  <= cmd.flush;
			out_q.final_symbol <= pend_final_q;
		end
	end

	assign out_valid = out_vld_q;
	assign out_data  = out_q;

	assign st.bits_left  = bit_cnt_q != BIT_CNT_W'(BYTE_BITS);
	assign st.last_bit   = bit_cnt_q == BIT_CNT_W'(BYTE_BITS - 1);
	assign st.total_hit  = given_q >= total_q;
	assign st.at_root    = at_root_q;
	assign st.rd_leaf    = rd.leaf;
	assign st.pend_valid = pend_vld_q;
	assign st.emit_ok    = !pend_vld_q || out_free;
	assign st.out_free   = out_free;

endmodule

// File: design/huffman_tree_walk_decoder.sv
// A load item is taken in IDLE. A data byte passes IDLE, then for each bit BIT, STEP and CHILD
// if it opens a step (first bit of the byte or the bit after a leaf), STEP and CHILD if it
// continues in the tree, BIT and STEP on a leaf root, then BIT and FLUSH, at once on a hit total.
// Throughput is one item at a time, set by the dependent node reads through the single
// table port with a registered read. Reset clears configuration, walk position, symbol count
// and the output register at once; the node table is not cleared and holds nothing until loaded.
// Top level of the tree-walk decoder.
//
// Data flow:
//   - load items write one node into the table and restart the walk at the root
//   - data items are walked bit by bit; each step reads one node, the child read
//     decides between a leaf (symbol out, back to root) and descending
//   - a decoded symbol is held back until the next one so the last symbol of a byte can be
//     marked last_of_run when the byte runs out or the symbol total is reached
//   - the output register lets the next item in while a result waits
// in_stall is high while a data byte is being walked.
module huffman_tree_walk_decoder
	import hufftw_pkg::*;
#(
	parameter int NODE_COUNT  = NODE_COUNT_DEF,
	parameter int SYMBOL_BITS = SYMBOL_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  in_item_t              in_data,
	output logic                  out_valid,
	input  logic                  out_stall,
	output out_item_t             out_data,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cmd_t    cmd;
	status_t st;
	logic    busy;

	// sequencer: decides which node read, emit or flush happens each cycle
	hufftw_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.req_type (in_data.req_type),
		.st       (st),
		.cmd      (cmd),
		.busy     (busy)
	);

	// table, walk registers, counters and output stage
	hufftw_dp #(
		.NODE_COUNT  (NODE_COUNT),
		.SYMBOL_BITS (SYMBOL_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.st        (st)
	);

	// items are taken only between bytes
	assign in_stall = busy;

endmodule

// File: design/hufftw_chk.sv
// Port-level checker for the tree-walk decoder, bound to the top level.
module hufftw_chk
	import hufftw_pkg::*;
(
	input logic                  clk,
	input logic                  arst_n,
	input logic                  in_valid,
	input logic                  in_stall,
	input in_item_t              in_data,
	input logic                  out_valid,
	input logic                  out_stall,
	input out_item_t             out_data,
	input logic                  cfg_we,
	input logic [CFG_IDX_W-1:0]  cfg_index,
	input logic [CFG_DATA_W-1:0] cfg_data
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("output item changed while stalled");

	a_final_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.final_symbol |-> out_data.last_of_run)
		else $error("symbol after the total within one byte");

	a_byte_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && in_data.req_type == REQ_DATA |=> in_stall)
		else $error("data item not followed by a busy walk");

	a_out_from_walk: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result appeared without a walk in progress");

	a_cfg_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |-> !in_stall && !$isunknown({cfg_index, cfg_data}))
		else $error("register written during a walk");

endmodule

bind huffman_tree_walk_decoder hufftw_chk u_chk (.*);

// File: tb/huffman_tree_walk_decoder_tb.sv
// Self-checking testbench for the tree-walk decoder: loaded trees, random streams, checked symbols.
module huffman_tree_walk_decoder_tb;
	import hufftw_pkg::*;

	localparam int NODE_COUNT   = NODE_COUNT_DEF;
	localparam int SETTLE       = 60;       // > worst byte walk with margin
	localparam int HOLD_CYCLES  = 400;      // long receiver hold-off
	localparam int RANDOM_ITEMS = 200;
	localparam int CALM_ITEMS   = 40;       // tail of the random part run without idling
	localparam int TIMEOUT      = 4000000;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_stall;
	in_item_t              in_data;
	logic                  out_valid;
	logic                  out_stall;
	out_item_t             out_data;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	huffman_tree_walk_decoder uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Predictor copy of the node table and walk state.
	logic             node_leaf   [NODE_COUNT];
	logic [IDX_W-1:0] node_lchild [NODE_COUNT];
	logic [IDX_W-1:0] node_rchild [NODE_COUNT];
	logic [SYM_W-1:0] node_sym    [NODE_COUNT];
	logic             node_loaded [NODE_COUNT];
	logic [IDX_W-1:0] loaded_list [$];   // written indices, safe targets for children

	logic [IDX_W-1:0]   walk_node;
	logic               walk_at_root;
	logic [TOTAL_W-1:0] given_count;

	// Predictor copy of the registers.
	logic [IDX_W-1:0]   cfg_root;
	logic               cfg_lsb_first;
	logic [TOTAL_W-1:0] cfg_total;

	out_item_t symbol_q [$];   // decoded symbols not yet seen at the output

	int  item_count;
	int  checked_count;
	int  phase_count;
	int  mismatch_count;
	bit  valid_up;    // in_valid currently scheduled high
	bit  no_idle;     // tail of the run: no random gaps or stalls
	bit  hold_req;    // ask the receiver for one long hold-off
	out_item_t want;

	// Decoder behavior for one accepted item; queues the symbols it yields.
	task automatic decode_item(input in_item_t it);
		out_item_t        run [BYTE_BITS];
		int               n;
		int               pos;
		logic [IDX_W-1:0] here;
		logic [IDX_W-1:0] nxt;
		logic             hit;
		logic [SYM_W-1:0] s;
		n = 0;
		if (it.req_type == REQ_LOAD) begin
			node_leaf[it.node_index]   = it.node_is_leaf;
			node_lchild[it.node_index] = it.node_left;
			node_rchild[it.node_index] = it.node_right;
			node_sym[it.node_index]    = it.node_symbol;
			if (!node_loaded[it.node_index]) begin
				node_loaded[it.node_index] = 1'b1;
				loaded_list.push_back(it.node_index);
			end
			walk_node    = '0;
			walk_at_root = 1'b1;
			given_count  = '0;
		end else begin
			for (int b = 0; b < BYTE_BITS; b++) begin
				if (given_count >= cfg_total)
					break;
				pos  = cfg_lsb_first ? b : BYTE_BITS - 1 - b;
				here = walk_at_root ? cfg_root : walk_node;
				hit  = 1'b0;
				s    = '0;
				if (walk_at_root && node_leaf[here]) begin
					// leaf root: every bit yields the root symbol
					hit = 1'b1;
					s   = node_sym[here];
				end else begin
					nxt = it.data_byte[pos] ? node_rchild[here] : node_lchild[here];
					if (node_leaf[nxt]) begin
						hit          = 1'b1;
						s            = node_sym[nxt];
						walk_at_root = 1'b1;
						walk_node    = cfg_root;
					end else begin
						walk_node    = nxt;
						walk_at_root = 1'b0;
					end
				end
				if (hit) begin
					given_count++;
					run[n].symbol       = s;
					run[n].last_of_run  = 1'b0;
					run[n].final_symbol = (given_count == cfg_total);
					n++;
				end
			end
			if (n > 0)
				run[n-1].last_of_run = 1'b1;
			for (int k = 0; k < n; k++)
				symbol_q.push_back(run[k]);
		end
	endtask

	function automatic in_item_t rand_item();
		logic [63:0] r;
		r = {$urandom, $urandom};
		return r[$bits(in_item_t)-1:0];
	endfunction

	// Offer one item, wait for the handshake, predict, then maybe idle.
	task automatic send_item(input in_item_t it);
		in_valid <= 1'b1;
		in_data  <= it;
		valid_up = 1'b1;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		decode_item(it);
		item_count++;
		if (!no_idle && $urandom_range(0, 99) < 25) begin
			in_valid <= 1'b0;
			valid_up = 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
	endtask

	task automatic load_node(input logic [IDX_W-1:0] idx, input logic leaf,
		input logic [IDX_W-1:0] lc, input logic [IDX_W-1:0] rc, input logic [SYM_W-1:0] sym);
		in_item_t it;
		it              = rand_item();   // data_byte stays random
		it.req_type     = REQ_LOAD;
		it.node_index   = idx;
		it.node_is_leaf = leaf;
		it.node_left    = lc;
		it.node_right   = rc;
		it.node_symbol  = sym;
		send_item(it);
	endtask

	task automatic send_byte(input logic [7:0] b);
		in_item_t it;
		it           = rand_item();      // node fields stay random, ignored
		it.req_type  = REQ_DATA;
		it.data_byte = b;
		send_item(it);
	endtask

	// Sender pause: nothing outstanding, then let a result-free walk finish.
	task automatic wait_idle();
		if (valid_up) begin
			in_valid <= 1'b0;
			valid_up = 1'b0;
		end
		while (symbol_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// All three registers, one per cycle, only with the block idle.
	task automatic set_config(input logic [IDX_W-1:0] root, input logic lsb_first,
		input logic [TOTAL_W-1:0] total);
		wait_idle();
		cfg_we    <= 1'b1;
		cfg_index <= CFG_ROOT;
		cfg_data  <= {{(CFG_DATA_W-IDX_W){1'b0}}, root};
		@(posedge clk);
		cfg_root  = root;
		cfg_index <= CFG_ORDER;
		cfg_data  <= {{(CFG_DATA_W-1){1'b0}}, lsb_first};
		@(posedge clk);
		cfg_lsb_first = lsb_first;
		cfg_index <= CFG_TOTAL;
		cfg_data  <= total;
		@(posedge clk);
		cfg_total = total;
		cfg_we    <= 1'b0;
	endtask

	// Random full binary tree, loaded children first so no inner node points at an
	// unwritten node. root_at >= 0 pins the root index (needs leaves >= 2).
	task automatic build_tree(input int leaves, input int root_at, output logic [IDX_W-1:0] root);
		bit               used [NODE_COUNT];
		logic [IDX_W-1:0] pool [$];
		logic [IDX_W-1:0] idx;
		logic [IDX_W-1:0] a;
		logic [IDX_W-1:0] b;
		logic [31:0]      r;
		int               k;
		if (root_at >= 0)
			used[root_at] = 1'b1;
		for (int i = 0; i < leaves; i++) begin
			do begin
				r   = $urandom;
				idx = r[IDX_W-1:0];
			end while (used[idx]);
			used[idx] = 1'b1;
			r = $urandom;
			load_node(idx, 1'b1, r[8:0], r[17:9], r[31:24]);
			pool.push_back(idx);
		end
		while (pool.size() > 1) begin
			k = $urandom_range(0, pool.size() - 1);
			a = pool[k];
			pool.delete(k);
			k = $urandom_range(0, pool.size() - 1);
			b = pool[k];
			pool.delete(k);
			if (pool.size() == 0 && root_at >= 0) begin
				idx = IDX_W'(root_at);
			end else begin
				do begin
					r   = $urandom;
					idx = r[IDX_W-1:0];
				end while (used[idx]);
				used[idx] = 1'b1;
			end
			r = $urandom;
			load_node(idx, 1'b0, a, b, r[7:0]);
			pool.push_back(idx);
		end
		root = pool[0];
	endtask

	// Stray load: any index; an inner node gets children only among written nodes.
	task automatic noise_load();
		logic [31:0]      r;
		logic [IDX_W-1:0] lc;
		logic [IDX_W-1:0] rc;
		r  = $urandom;
		lc = loaded_list[$urandom_range(0, loaded_list.size() - 1)];
		rc = loaded_list[$urandom_range(0, loaded_list.size() - 1)];
		if (r[9])
			load_node(r[8:0], 1'b1, r[18:10], r[27:19], r[31:24]);
		else
			load_node(r[8:0], 1'b0, lc, rc, r[31:24]);
	endtask

	// Fixed tree at extreme indices. Codes: 0 -> 5A, 10 -> 00, 11 -> FF.
	task automatic test_fixed_tree();
		load_node(9'd0,   1'b1, 9'd511, 9'd0,   8'h00);
		load_node(9'd511, 1'b1, 9'd0,   9'd511, 8'hFF);
		load_node(9'd256, 1'b1, 9'h155, 9'h0AA, 8'h5A);
		load_node(9'd300, 1'b0, 9'd0,   9'd511, 8'h33);
		load_node(9'd1,   1'b0, 9'd256, 9'd300, 8'hCC);
		set_config(9'd1, ORDER_MSB_FIRST, 32'hFFFF_FFFF);
		send_byte(8'h00);   // eight one-bit codes
		send_byte(8'hFF);
		send_byte(8'hB6);
		send_byte(8'h01);   // trailing 1 carries into the next byte
		send_byte(8'h80);
	endtask

	task automatic test_lsb_order_and_root_change();
		set_config(9'd1, ~ORDER_MSB_FIRST, 32'hFFFF_FFFF);
		send_byte(8'h6D);
		send_byte(8'h80);   // ends mid-code, walk waits at node 300
		// root moved to a leaf while inside the tree: the walk finishes from 300
		set_config(9'd0, ORDER_MSB_FIRST, 32'hFFFF_FFFF);
		send_byte(8'h00);
		send_byte(8'hFF);   // leaf root: one symbol per bit
	endtask

	task automatic test_symbol_total();
		set_config(9'd1, ORDER_MSB_FIRST, 32'd3);
		load_node(9'd256, 1'b1, 9'd3, 9'd4, 8'h5A);   // reload clears the count
		send_byte(8'h00);   // stops after the third symbol
		send_byte(8'h00);   // total already reached
		set_config(9'd1, ORDER_MSB_FIRST, 32'd0);
		load_node(9'd256, 1'b1, 9'd3, 9'd4, 8'h5A);
		send_byte(8'hFF);   // zero total decodes nothing
	endtask

	task automatic test_leafless_cycle();
		load_node(9'd400, 1'b0, 9'd400, 9'd400, 8'h11);
		load_node(9'd401, 1'b0, 9'd0,   9'd401, 8'h22);
		set_config(9'd400, ORDER_MSB_FIRST, 32'hFFFF_FFFF);
		send_byte(8'hA5);   // bits consumed, nothing out
		set_config(9'd401, ORDER_MSB_FIRST, 32'hFFFF_FFFF);
		// walk is still inside the 400 loop; a reload sends it back to the root
		load_node(9'd401, 1'b0, 9'd0,   9'd401, 8'h22);
		send_byte(8'hFE);   // loops on 1s, leaves on the final 0
	endtask

	// Output held for a long stretch while bytes keep coming: block must fill and stall.
	task automatic test_output_hold();
		logic [IDX_W-1:0] root;
		logic [31:0]      r;
		build_tree(3, -1, root);
		set_config(root, ORDER_MSB_FIRST, 32'hFFFF_FFFF);
		hold_req = 1'b1;
		for (int i = 0; i < 16; i++) begin
			r = $urandom;
			send_byte(r[7:0]);
		end
		wait_idle();
	endtask

	task automatic test_random_streams();
		logic [IDX_W-1:0]   root;
		logic [TOTAL_W-1:0] total;
		logic [31:0]        r;
		int                 leaves;
		int                 root_at;
		int                 start;
		int                 sel;
		start = item_count;
		while (item_count - start < RANDOM_ITEMS) begin
			if (item_count - start >= RANDOM_ITEMS - CALM_ITEMS)
				no_idle = 1'b1;
			leaves  = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 10);
			root_at = -1;
			if (leaves >= 2 && phase_count == 0)
				root_at = NODE_COUNT - 1;
			else if (leaves >= 2 && phase_count == 1)
				root_at = 0;
			build_tree(leaves, root_at, root);
			sel = $urandom_range(0, 9);
			if (sel < 6)
				total = 32'hFFFF_FFFF;
			else if (sel < 9)
				total = $urandom_range(1, 40);
			else
				total = $urandom;
			r = $urandom;
			set_config(root, r[0], total);
			for (int i = $urandom_range(6, 16); i > 0; i--) begin
				r = $urandom;
				if (r[31:27] == 5'd0)
					noise_load();   // breaks the stream: walk and count restart
				else
					send_byte(r[7:0]);
			end
			phase_count++;
		end
	endtask

	// Receiver: random stall bursts, plus one long hold on request.
	initial begin
		out_stall <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				out_stall <= 1'b0;
				hold_req = 1'b0;
			end else if (!no_idle && $urandom_range(0, 99) < 12) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 13)) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	// Every accepted result against the oldest predicted symbol.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (symbol_q.size() == 0) begin
				$error("unexpected result item: symbol %0h", out_data.symbol);
				mismatch_count++;
			end else begin
				want = symbol_q.pop_front();
				checked_count++;
				if (out_data.symbol !== want.symbol) begin
					$error("symbol: expected %0h, got %0h", want.symbol, out_data.symbol);
					mismatch_count++;
				end
				if (out_data.last_of_run !== want.last_of_run) begin
					$error("last_of_run: expected %0b, got %0b",
						want.last_of_run, out_data.last_of_run);
					mismatch_count++;
				end
				if (out_data.final_symbol !== want.final_symbol) begin
					$error("final_symbol: expected %0b, got %0b",
						want.final_symbol, out_data.final_symbol);
					mismatch_count++;
				end
			end
		end
	end

	initial begin
		#TIMEOUT;
		$display("Mismatches found");
		$finish;
	end

	initial begin
		for (int i = 0; i < NODE_COUNT; i++) begin
			node_leaf[i]   = 1'b0;
			node_lchild[i] = '0;
			node_rchild[i] = '0;
			node_sym[i]    = '0;
			node_loaded[i] = 1'b0;
		end
		walk_node      = '0;
		walk_at_root   = 1'b1;
		given_count    = '0;
		cfg_root       = '0;
		cfg_lsb_first  = ORDER_MSB_FIRST;
		cfg_total      = '0;
		item_count     = 0;
		checked_count  = 0;
		phase_count    = 0;
		mismatch_count = 0;
		valid_up       = 1'b0;
		no_idle        = 1'b0;
		hold_req       = 1'b0;

		arst_n    <= 1'b0;
		in_valid  <= 1'b0;
		in_data   <= '0;
		cfg_we    <= 1'b0;
		cfg_index <= CFG_ROOT;
		cfg_data  <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_fixed_tree();
		test_lsb_order_and_root_change();
		test_symbol_total();
		test_leafless_cycle();
		test_output_hold();
		test_random_streams();
		wait_idle();

		$display("Sent %0d items (%0d random tree phases), checked %0d decoded symbols.",
			item_count, phase_count, checked_count);
		$display("Covered both bit orders, leaf roots, leafless loops, totals 0 to max, long hold.");
		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

// File: sim.f
design/hufftw_pkg.sv
design/hufftw_ctrl.sv
design/hufftw_dp.sv
design/huffman_tree_walk_decoder.sv
design/hufftw_chk.sv
tb/huffman_tree_walk_decoder_tb.sv
